[hw/rtl/bdc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Business day counter package
// Shared request, job and result types, calendar constants and the small
// calendar lookup functions used by the front and back parts.
// ----------------------------------------------------------------------------
package bdc_pkg;

	// Request as it arrives on the input queue port.
	typedef struct packed {
		logic [4:0]  start_day;
		logic [3:0]  start_month;
		logic [13:0] start_year;
		logic [4:0]  end_day;
		logic [3:0]  end_month;
		logic [13:0] end_year;
	} bdc_request_t;

	// Result as it leaves on the output queue port.
	typedef struct packed {
		logic [14:0] business_days;
		logic        status;
	} bdc_result_t;

	// Classified job handed from the front part to the back part.
	typedef struct packed {
		logic [4:0]  start_day;
		logic [3:0]  start_month;
		logic [13:0] start_year;
		logic [4:0]  end_day;
		logic [3:0]  end_month;
		logic [13:0] end_year;
		logic [2:0]  weekday;
		logic [6:0]  year_in_century;
		logic [1:0]  century_mod4;
		logic        is_valid;
		logic        is_forward;
	} bdc_job_t;

	localparam int BDC_REQUEST_W = $bits(bdc_request_t);
	localparam int BDC_RESULT_W  = $bits(bdc_result_t);
	localparam int BDC_JOB_W     = $bits(bdc_job_t);

	localparam int BDC_QUEUE_DEPTH = 2;

	localparam logic [6:0]  BDC_MASK_RESET = 7'd96;
	localparam logic [6:0]  BDC_MASK_ALL   = 7'h7F;
	localparam logic [14:0] BDC_TALLY_MAX  = 15'd32767;
	localparam logic [13:0] BDC_YEAR_MAX   = 14'd9999;
	localparam logic [3:0]  BDC_MONTH_JAN  = 4'd1;
	localparam logic [3:0]  BDC_MONTH_FEB  = 4'd2;
	localparam logic [3:0]  BDC_MONTH_DEC  = 4'd12;
	localparam logic [2:0]  BDC_WEEK_LAST  = 3'd6;
	localparam logic [6:0]  BDC_CENTURY_LAST = 7'd99;

	// Reciprocal constants: x/100 exact for x < 43690, x/7 exact for x < 43690.
	localparam logic [12:0] BDC_DIV100_MUL   = 13'd5243;
	localparam int          BDC_DIV100_SHIFT = 19;
	localparam logic [6:0]  BDC_HUNDRED      = 7'd100;
	localparam logic [15:0] BDC_DIV7_MUL     = 16'd37450;
	localparam int          BDC_DIV7_SHIFT   = 18;
	localparam logic [2:0]  BDC_SEVEN        = 3'd7;

	// Gregorian leap rule from the year's low bits, year within century and
	// century count modulo four.
	function automatic logic bdc_is_leap(input logic [1:0] year_low,
		input logic [6:0] year_in_century, input logic [1:0] century_mod4);
		logic by_four;
		logic by_century;
		by_four    = (year_low == 2'd0) && (year_in_century != 7'd0);
		by_century = (year_in_century == 7'd0) && (century_mod4 == 2'd0);
		return by_four || by_century;
	endfunction

	// Month length; zero for a month code outside the calendar.
	function automatic logic [4:0] bdc_days_in_month(input logic [3:0] month,
		input logic leap);
		logic [4:0] len;
		unique case (month)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                   len = 5'd30;
			4'd2:                                      len = leap ? 5'd29 : 5'd28;
			default:                                   len = 5'd0;
		endcase
		return len;
	endfunction

	// Month term (31*mm)/12 of the weekday formula, with January and February
	// counted as months eleven and twelve of the year before.
	function automatic logic [4:0] bdc_month_offset(input logic [3:0] month);
		logic [4:0] ofs;
		unique case (month)
			4'd1:    ofs = 5'd28;
			4'd2:    ofs = 5'd31;
			4'd3:    ofs = 5'd2;
			4'd4:    ofs = 5'd5;
			4'd5:    ofs = 5'd7;
			4'd6:    ofs = 5'd10;
			4'd7:    ofs = 5'd12;
			4'd8:    ofs = 5'd15;
			4'd9:    ofs = 5'd18;
			4'd10:   ofs = 5'd20;
			4'd11:   ofs = 5'd23;
			4'd12:   ofs = 5'd25;
			default: ofs = 5'd0;
		endcase
		return ofs;
	endfunction

endpackage

[hw/rtl/bdc_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Business day counter queue
// Small register queue with push/full and pop/empty sides, used between the
// front and back parts and in front of the result port.
// ----------------------------------------------------------------------------
module bdc_fifo #(
	parameter int Width = 8,
	parameter int Depth = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic [Width-1:0] wdata,
	input  logic             pop,
	output logic             empty,
	output logic [Width-1:0] rdata
);

	localparam int AddrW  = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CountW = $clog2(Depth + 1);
	localparam logic [AddrW-1:0]  LastAddr = AddrW'(Depth - 1);
	localparam logic [CountW-1:0] FullCount = CountW'(Depth);

	logic [Width-1:0]  mem_q [Depth];
	logic [AddrW-1:0]  wr_ptr_q;
	logic [AddrW-1:0]  rd_ptr_q;
	logic [CountW-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign full    = (count_q == FullCount);
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	// Storage; entries need no reset.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LastAddr) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LastAddr) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[hw/rtl/bdc_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Business day counter front part
// Accepts a request, checks both dates, compares their order and works out
// the start weekday, then hands a classified job to the job queue.
// ----------------------------------------------------------------------------
module bdc_front
	import bdc_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	output logic         full,
	input  bdc_request_t request,
	output logic         job_push,
	input  logic         job_full,
	output bdc_job_t     job
);

	typedef enum logic [3:0] {
		F_IDLE = 4'b0001,
		F_DIV  = 4'b0010,
		F_SUM  = 4'b0100,
		F_PUSH = 4'b1000
	} front_state_t;

	front_state_t state_q;
	front_state_t state_d;

	bdc_request_t req_q;
	logic [7:0]   cent_start_q;
	logic [7:0]   cent_end_q;
	logic [7:0]   cent_shift_q;
	logic [14:0]  sum_q;
	logic         valid_q;
	logic         forward_q;
	logic [6:0]   yic_start_q;

	logic         early;
	logic [13:0]  shift_year;
	logic [26:0]  prod_start;
	logic [26:0]  prod_end;
	logic [26:0]  prod_shift;
	logic [6:0]   yic_start;
	logic [6:0]   yic_end;
	logic         leap_start;
	logic         leap_end;
	logic [4:0]   dim_start;
	logic [4:0]   dim_end;
	logic         ok_start;
	logic         ok_end;
	logic [14:0]  sum_d;
	logic [30:0]  prod_seven;
	logic [12:0]  week_count;
	logic [14:0]  week_rem;

	assign full = (state_q != F_IDLE);

	// January and February belong to the previous year in the weekday formula.
	assign early      = (req_q.start_month <= BDC_MONTH_FEB);
	assign shift_year = req_q.start_year - 14'(early);

	// Century counts by reciprocal multiplication.
	assign prod_start = 27'(req_q.start_year) * 27'(BDC_DIV100_MUL);
	assign prod_end   = 27'(req_q.end_year) * 27'(BDC_DIV100_MUL);
	assign prod_shift = 27'(shift_year) * 27'(BDC_DIV100_MUL);

	// Date checks from the registered century counts.
	always_comb begin
		yic_start  = 7'(req_q.start_year - 14'(cent_start_q) * 14'(BDC_HUNDRED));
		yic_end    = 7'(req_q.end_year - 14'(cent_end_q) * 14'(BDC_HUNDRED));
		leap_start = bdc_is_leap(req_q.start_year[1:0], yic_start, cent_start_q[1:0]);
		leap_end   = bdc_is_leap(req_q.end_year[1:0], yic_end, cent_end_q[1:0]);
		dim_start  = bdc_days_in_month(req_q.start_month, leap_start);
		dim_end    = bdc_days_in_month(req_q.end_month, leap_end);
		ok_start   = (req_q.start_year != '0) && (req_q.start_year <= BDC_YEAR_MAX)
			&& (req_q.start_day != '0) && (req_q.start_day <= dim_start);
		ok_end     = (req_q.end_year != '0) && (req_q.end_year <= BDC_YEAR_MAX)
			&& (req_q.end_day != '0) && (req_q.end_day <= dim_end);
		sum_d      = 15'(req_q.start_day) + 15'(shift_year) + 15'(shift_year >> 2)
			- 15'(cent_shift_q) + 15'(cent_shift_q >> 2)
			+ 15'(bdc_month_offset(req_q.start_month));
	end

	// Weekday as the weekday sum modulo seven.
	assign prod_seven = 31'(sum_q) * 31'(BDC_DIV7_MUL);
	assign week_count = 13'(prod_seven >> BDC_DIV7_SHIFT);
	assign week_rem   = sum_q - 15'(week_count) * 15'(BDC_SEVEN);

	// Job handed to the back part.
	always_comb begin
		job.start_day       = req_q.start_day;
		job.start_month     = req_q.start_month;
		job.start_year      = req_q.start_year;
		job.end_day         = req_q.end_day;
		job.end_month       = req_q.end_month;
		job.end_year        = req_q.end_year;
		job.weekday         = week_rem[2:0];
		job.year_in_century = yic_start_q;
		job.century_mod4    = cent_start_q[1:0];
		job.is_valid        = valid_q;
		job.is_forward      = forward_q;
	end

	assign job_push = (state_q == F_PUSH);

	// Sequencer next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			F_IDLE: begin
				if (push) begin
					state_d = F_DIV;
				end
			end
			F_DIV:  state_d = F_SUM;
			F_SUM:  state_d = F_PUSH;
			F_PUSH: begin
				if (!job_full) begin
					state_d = F_IDLE;
				end
			end
			default: state_d = F_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Working registers of the request in flight.
	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && push) begin
			req_q <= request;
		end
		if (state_q == F_DIV) begin
			cent_start_q <= 8'(prod_start >> BDC_DIV100_SHIFT);
			cent_end_q   <= 8'(prod_end >> BDC_DIV100_SHIFT);
			cent_shift_q <= 8'(prod_shift >> BDC_DIV100_SHIFT);
		end
		if (state_q == F_SUM) begin
			sum_q       <= sum_d;
			valid_q     <= ok_start && ok_end;
			forward_q   <= {req_q.start_year, req_q.start_month, req_q.start_day}
				< {req_q.end_year, req_q.end_month, req_q.end_day};
			yic_start_q <= yic_start;
		end
	end

endmodule

[hw/rtl/bdc_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Business day counter back part
// Takes classified jobs, walks the calendar one day per cycle while tallying
// days whose weekday is not in the weekend mask, and posts the result.
// ----------------------------------------------------------------------------
module bdc_back
	import bdc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic [6:0]  weekend_mask,
	input  logic        job_empty,
	output logic        job_pop,
	input  bdc_job_t    job,
	output logic        res_push,
	input  logic        res_full,
	output bdc_result_t res
);

	typedef enum logic [2:0] {
		B_IDLE = 3'b001,
		B_WALK = 3'b010,
		B_DONE = 3'b100
	} back_state_t;

	back_state_t state_q;

	logic [4:0]  cur_day_q;
	logic [3:0]  cur_month_q;
	logic [13:0] cur_year_q;
	logic [2:0]  weekday_q;
	logic [6:0]  yic_q;
	logic [1:0]  cent4_q;
	logic [4:0]  end_day_q;
	logic [3:0]  end_month_q;
	logic [13:0] end_year_q;
	logic [14:0] tally_q;
	logic        status_q;

	logic        at_end;
	logic        walk_done;
	logic        leap;
	logic [4:0]  month_len;

	assign job_pop  = (state_q == B_IDLE) && !job_empty;
	assign res_push = (state_q == B_DONE);
	assign res.business_days = tally_q;
	assign res.status        = status_q;

	// The walk stops at the end date, at saturation, or when no day counts.
	assign at_end    = (cur_day_q == end_day_q) && (cur_month_q == end_month_q)
		&& (cur_year_q == end_year_q);
	assign walk_done = at_end || (tally_q == BDC_TALLY_MAX) || (weekend_mask == BDC_MASK_ALL);
	assign leap      = bdc_is_leap(cur_year_q[1:0], yic_q, cent4_q);
	assign month_len = bdc_days_in_month(cur_month_q, leap);

	// Control sequence.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
		end else begin
			unique case (state_q)
				B_IDLE: begin
					if (!job_empty) begin
						state_q <= (job.is_valid && job.is_forward) ? B_WALK : B_DONE;
					end
				end
				B_WALK: begin
					if (walk_done) begin
						state_q <= B_DONE;
					end
				end
				B_DONE: begin
					if (!res_full) begin
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	// Walk registers: current date, weekday, leap tracking and tally.
	always_ff @(posedge clk) begin
		if (job_pop) begin
			cur_day_q   <= job.start_day;
			cur_month_q <= job.start_month;
			cur_year_q  <= job.start_year;
			weekday_q   <= job.weekday;
			yic_q       <= job.year_in_century;
			cent4_q     <= job.century_mod4;
			end_day_q   <= job.end_day;
			end_month_q <= job.end_month;
			end_year_q  <= job.end_year;
			tally_q     <= '0;
			status_q    <= !job.is_valid;
		end else if (state_q == B_WALK && !walk_done) begin
			if (!weekend_mask[weekday_q]) begin
				tally_q <= tally_q + 1'b1;
			end
			weekday_q <= (weekday_q == BDC_WEEK_LAST) ? 3'd0 : weekday_q + 1'b1;
			if (cur_day_q == month_len) begin
				cur_day_q <= 5'd1;
				if (cur_month_q == BDC_MONTH_DEC) begin
					cur_month_q <= BDC_MONTH_JAN;
					cur_year_q  <= cur_year_q + 1'b1;
					if (yic_q == BDC_CENTURY_LAST) begin
						yic_q   <= '0;
						cent4_q <= cent4_q + 1'b1;
					end else begin
						yic_q <= yic_q + 1'b1;
					end
				end else begin
					cur_month_q <= cur_month_q + 1'b1;
				end
			end else begin
				cur_day_q <= cur_day_q + 1'b1;
			end
		end
	end

	// A walk only runs on a valid job.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_WALK) |-> !status_q)
		else $error("walk running on an invalid job");

	// An invalid job goes straight to the result with status set.
	assert property (@(posedge clk) disable iff (!arst_n)
		(job_pop && !job.is_valid) |=> (state_q == B_DONE) && status_q)
		else $error("invalid job did not report status");

	// The walk never passes the end date.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_WALK) |-> ({cur_year_q, cur_month_q, cur_day_q}
			<= {end_year_q, end_month_q, end_day_q}))
		else $error("walk passed the end date");

	// An error result always carries a zero count.
	assert property (@(posedge clk) disable iff (!arst_n)
		(res_push && res.status) |-> (res.business_days == '0))
		else $error("error result with nonzero count");

endmodule

[hw/rtl/business_day_counter_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Business day counter
// Counts the days from a start date up to but not including an end date whose
// weekday is not marked in the weekend mask.
//
// Input side: a queue port. A request (start and end date) is taken at a
// clock edge with push high and full low. Result side: a queue port. The
// oldest result sits on the result port while empty is low and leaves at an
// edge with pop high. cfg_we writes cfg_wdata to the weekend mask.
// The front part checks the dates and finds the start weekday in its divide
// and sum states, then queues the job. The back part walks the calendar one
// day per cycle; the walk ends early once the count saturates at 32767 or
// when every weekday is masked. An invalid date, an empty range or a reversed
// range skips the walk. The front accepts a new request while the back walks.
// A stalled result side fills the result queue, then the job queue, and then
// raises full. Reset empties both queues and sets the mask to Friday and
// Saturday.
// ----------------------------------------------------------------------------
module business_day_counter_top
	import bdc_pkg::*;
#(
	parameter int QueueDepth = BDC_QUEUE_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	output logic         full,
	input  bdc_request_t request,
	output logic         empty,
	input  logic         pop,
	output bdc_result_t  result,
	input  logic         cfg_we,
	input  logic [6:0]   cfg_wdata
);

	logic        weekend_mask_q;
	logic [6:0]  mask_q;
	logic        job_push;
	logic        job_full;
	bdc_job_t    job_in;
	logic        job_pop;
	logic        job_empty;
	logic [BDC_JOB_W-1:0] job_bits;
	bdc_job_t    job_out;
	logic        res_push;
	logic        res_full;
	bdc_result_t res_in;
	logic [BDC_RESULT_W-1:0] res_bits;

	// Weekend mask register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q         <= BDC_MASK_RESET;
			weekend_mask_q <= 1'b0;
		end else if (cfg_we) begin
			mask_q         <= cfg_wdata;
			weekend_mask_q <= 1'b1;
		end
	end

	// Front part: checks and classifies requests.
	bdc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.request  (request),
		.job_push (job_push),
		.job_full (job_full),
		.job      (job_in)
	);

	// Job queue between the two parts.
	bdc_fifo #(
		.Width (BDC_JOB_W),
		.Depth (QueueDepth)
	) u_job_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (job_push),
		.full   (job_full),
		.wdata  (job_in),
		.pop    (job_pop),
		.empty  (job_empty),
		.rdata  (job_bits)
	);

	assign job_out = bdc_job_t'(job_bits);

	// Back part: walks the range and counts.
	bdc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.weekend_mask (mask_q),
		.job_empty    (job_empty),
		.job_pop      (job_pop),
		.job          (job_out),
		.res_push     (res_push),
		.res_full     (res_full),
		.res          (res_in)
	);

	// Result queue in front of the output port.
	bdc_fifo #(
		.Width (BDC_RESULT_W),
		.Depth (QueueDepth)
	) u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.full   (res_full),
		.wdata  (res_in),
		.pop    (pop),
		.empty  (empty),
		.rdata  (res_bits)
	);

	assign result = bdc_result_t'(res_bits);

	// The mask must still read its reset value until the first write.
	assert property (@(posedge clk) disable iff (!arst_n)
		!weekend_mask_q |-> (mask_q == BDC_MASK_RESET))
		else $error("weekend mask changed without a write");

endmodule

[dv/bdc_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Business day counter checker
// Sits beside the counter and watches its queue ports and mask writes. For
// every accepted request it works out the expected count and status from its
// own calendar arithmetic and its own copy of the weekend mask. It then
// compares each popped result with the oldest expectation.
// ----------------------------------------------------------------------------
module bdc_checker
	import bdc_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic         full,
	input  bdc_request_t request,
	input  logic         empty,
	input  logic         pop,
	input  bdc_result_t  result,
	input  logic         cfg_we,
	input  logic [6:0]   cfg_wdata,
	output int           failures,
	output int           results_pending,
	output int           results_checked,
	output int           bad_dates_seen,
	output int           saturated_seen
);

	localparam logic STATUS_OK       = 1'b0;
	localparam logic STATUS_BAD_DATE = 1'b1;
	// Printing stops here so that a broken design cannot flood the log.
	localparam int   MAX_REPORTS     = 200;

	bdc_result_t expected_counts[$];
	logic [6:0]  weekend_copy = BDC_MASK_RESET;
	int          failure_tally = 0;
	int          checked_tally = 0;
	int          bad_date_tally = 0;
	int          saturated_tally = 0;

	assign failures        = failure_tally;
	assign results_checked = checked_tally;
	assign bad_dates_seen  = bad_date_tally;
	assign saturated_seen  = saturated_tally;

	// Gregorian leap rule: every fourth year, except centuries not divisible by 400.
	function automatic bit leap_year(input int year);
		return ((year % 4 == 0) && (year % 100 != 0)) || (year % 400 == 0);
	endfunction

	function automatic int month_length(input int year, input int month);
		int len;
		if (month == 2) begin
			len = leap_year(year) ? 29 : 28;
		end else if (month == 4 || month == 6 || month == 9 || month == 11) begin
			len = 30;
		end else if (month >= 1 && month <= 12) begin
			len = 31;
		end else begin
			len = 0;
		end
		return len;
	endfunction

	function automatic bit date_valid(input int day, input int month, input int year);
		if (month < 1 || month > 12) return 1'b0;
		if (year < 1 || year > int'(BDC_YEAR_MAX)) return 1'b0;
		return (day >= 1) && (day <= month_length(year, month));
	endfunction

	// Days since a fixed origin, with the year starting in March.
	function automatic int day_serial(input int day, input int month, input int year);
		int shift;
		int yy;
		int mm;
		shift = (month <= 2) ? 1 : 0;
		yy    = year - shift;
		mm    = month + 12 * shift - 3;
		return 365 * yy + yy / 4 - yy / 100 + yy / 400 + (153 * mm + 2) / 5 + day;
	endfunction

	// Weekday of a valid date, Sunday being zero.
	function automatic int start_weekday(input int day, input int month, input int year);
		int shift;
		int yy;
		int mm;
		shift = (14 - month) / 12;
		yy    = year - shift;
		mm    = month + 12 * shift - 2;
		return (day + yy + yy / 4 - yy / 100 + yy / 400 + (31 * mm) / 12) % 7;
	endfunction

	// Expected result of one request under the given weekend mask.
	function automatic bdc_result_t predict_count(input bdc_request_t req,
		input logic [6:0] mask);
		int          sd, sm, sy, ed, em, ey;
		int          span;
		int          first_wd;
		int          per_week;
		int          total;
		bdc_result_t res;
		sd = int'(req.start_day);
		sm = int'(req.start_month);
		sy = int'(req.start_year);
		ed = int'(req.end_day);
		em = int'(req.end_month);
		ey = int'(req.end_year);
		res.business_days = '0;
		res.status        = STATUS_OK;
		if (!date_valid(sd, sm, sy) || !date_valid(ed, em, ey)) begin
			res.status = STATUS_BAD_DATE;
			return res;
		end
		span = day_serial(ed, em, ey) - day_serial(sd, sm, sy);
		if (span < 0) span = 0;
		first_wd = start_weekday(sd, sm, sy);
		// Whole weeks contribute the unmasked weekdays each; the leftover days
		// are counted one by one from the start weekday.
		per_week = 0;
		for (int k = 0; k < 7; k++) begin
			if (!mask[k]) per_week++;
		end
		total = (span / 7) * per_week;
		for (int k = 0; k < span % 7; k++) begin
			if (!mask[(first_wd + k) % 7]) total++;
		end
		res.business_days = (total > int'(BDC_TALLY_MAX)) ? BDC_TALLY_MAX : 15'(total);
		return res;
	endfunction

	task automatic report_mismatch(input string what);
		if (failure_tally < MAX_REPORTS) $display("%0t ns: mismatch: %s", $time, what);
		failure_tally++;
	endtask

	// Record mask writes, predict on each accepted request, compare on each pop.
	always @(posedge clk or negedge arst_n) begin : watch_ports
		bdc_result_t due;
		if (!arst_n) begin
			expected_counts.delete();
			weekend_copy = BDC_MASK_RESET;
			results_pending <= 0;
		end else begin
			if (cfg_we) weekend_copy = cfg_wdata;
			if (push && !full) expected_counts.push_back(predict_count(request, weekend_copy));
			if (pop && !empty) begin
				if (expected_counts.size() == 0) begin
					report_mismatch($sformatf("result count %0d status %0d with no request waiting",
						result.business_days, result.status));
				end else begin
					due = expected_counts.pop_front();
					checked_tally++;
					if (due.status == STATUS_BAD_DATE) bad_date_tally++;
					if (due.business_days == BDC_TALLY_MAX) saturated_tally++;
					if (result.status !== due.status)
						report_mismatch($sformatf("result %0d: status %b, expected %b",
							checked_tally, result.status, due.status));
					if (result.business_days !== due.business_days)
						report_mismatch($sformatf("result %0d: business_days %0d, expected %0d",
							checked_tally, result.business_days, due.business_days));
				end
			end
			results_pending <= expected_counts.size();
		end
	end

endmodule

[dv/tb_business_day_counter_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Business day counter testbench
// Drives date range requests into the counter under several weekend masks:
// a directed set of calendar corner cases and saturating ranges, then random
// ranges, reversed ranges and corrupted dates. Both ports idle at random, and
// once the result side stalls long enough to back up the input. The checker
// beside the counter predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_business_day_counter_top;
	import bdc_pkg::*;

	localparam int         RANDOM_REQUESTS = 558;
	localparam int         RANDOM_PHASES   = 6;
	localparam int         HOLD_AT_REQUEST = 45;
	localparam int         HOLD_CYCLES     = 1500;
	localparam int         TAIL_CYCLES     = 20;
	localparam int         CYCLE_LIMIT     = 6_000_000;
	localparam logic [6:0] MASK_NONE       = 7'h00;
	localparam logic [6:0] MASK_SUN        = 7'h01;
	localparam logic [6:0] MASK_SUN_SAT    = 7'h41;

	logic         clk;
	logic         arst_n;
	logic         push;
	logic         full;
	bdc_request_t request;
	logic         empty;
	logic         pop;
	bdc_result_t  result;
	logic         cfg_we;
	logic [6:0]   cfg_wdata;

	int failures;
	int results_pending;
	int results_checked;
	int bad_dates_seen;
	int saturated_seen;
	int requests_sent = 0;
	int masks_written = 0;
	int cycle_count = 0;

	business_day_counter_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.request   (request),
		.empty     (empty),
		.pop       (pop),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	bdc_checker watcher (
		.clk             (clk),
		.arst_n          (arst_n),
		.push            (push),
		.full            (full),
		.request         (request),
		.empty           (empty),
		.pop             (pop),
		.result          (result),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.failures        (failures),
		.results_pending (results_pending),
		.results_checked (results_checked),
		.bad_dates_seen  (bad_dates_seen),
		.saturated_seen  (saturated_seen)
	);

	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Run guard.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	function automatic int days_of_month(input int year, input int month);
		if (month == 2)
			return (((year % 4 == 0) && (year % 100 != 0)) || (year % 400 == 0)) ? 29 : 28;
		if (month == 4 || month == 6 || month == 9 || month == 11) return 30;
		return 31;
	endfunction

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 75) return $urandom_range(1, 3);
		if (roll < 95) return $urandom_range(4, 12);
		return $urandom_range(30, 80);
	endfunction

	// Steps a date forward; running past December 9999 yields year 10000.
	function automatic void advance_days(inout int day, inout int month, inout int year,
		input int days);
		repeat (days) begin
			day++;
			if (day > days_of_month(year, month)) begin
				day = 1;
				month++;
				if (month > 12) begin
					month = 1;
					year++;
				end
			end
		end
	endfunction

	function automatic int bad_day(input int year, input int month);
		int len;
		len = days_of_month(year, month);
		if (len == 31 || $urandom_range(0, 1) == 0) return 0;
		return $urandom_range(len + 1, 31);
	endfunction

	// Yields 0, 13, 14 or 15.
	function automatic int bad_month();
		int month;
		month = $urandom_range(12, 15);
		return (month == 12) ? 0 : month;
	endfunction

	function automatic int bad_year();
		if ($urandom_range(0, 3) == 0) return 0;
		return $urandom_range(10000, 16383);
	endfunction

	// Offers one request and waits until the counter takes it.
	task automatic send_dates(input int sd, input int sm, input int sy,
		input int ed, input int em, input int ey);
		bdc_request_t req;
		req.start_day   = 5'(sd);
		req.start_month = 4'(sm);
		req.start_year  = 14'(sy);
		req.end_day     = 5'(ed);
		req.end_month   = 4'(em);
		req.end_year    = 14'(ey);
		push    <= 1'b1;
		request <= req;
		do @(posedge clk); while (full);
		requests_sent++;
	endtask

	task automatic sender_pause(input int pct);
		if ($urandom_range(0, 99) < pct) begin
			push <= 1'b0;
			repeat (pick_gap()) @(posedge clk);
		end
	endtask

	// Stops offering and waits until every request has its result back.
	task automatic wait_for_drain();
		push <= 1'b0;
		do @(posedge clk); while (results_pending != 0);
	endtask

	task automatic write_weekend_mask(input logic [6:0] mask);
		wait_for_drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= mask;
		@(posedge clk);
		cfg_we <= 1'b0;
		masks_written++;
	endtask

	// One random request: mostly forward ranges of a few weeks, some longer,
	// plus reversed ranges, corrupted dates and ranges around leap days.
	task automatic random_request();
		int sd, sm, sy, ed, em, ey;
		int kind;
		int roll;
		int span;
		kind = $urandom_range(0, 99);
		if (kind >= 92) begin
			case ($urandom_range(0, 6))
				0: sy = 4;
				1: sy = 100;
				2: sy = 400;
				3: sy = 1900;
				4: sy = 2000;
				5: sy = 2100;
				default: sy = 9996;
			endcase
			sm = BDC_MONTH_FEB;
			sd = $urandom_range(27, 29);
		end else begin
			sy = $urandom_range(1, 9999);
			sm = $urandom_range(1, 12);
			sd = $urandom_range(1, days_of_month(sy, sm));
		end
		roll = $urandom_range(0, 99);
		if (roll < 85) span = $urandom_range(0, 60);
		else if (roll < 97) span = $urandom_range(61, 800);
		else span = $urandom_range(801, 2000);
		ed = sd;
		em = sm;
		ey = sy;
		advance_days(ed, em, ey, span);
		if (kind >= 72 && kind < 80) begin
			{sd, sm, sy, ed, em, ey} = {ed, em, ey, sd, sm, sy};
		end else if (kind >= 80 && kind < 92) begin
			case ($urandom_range(0, 5))
				0: sd = bad_day(sy, sm);
				1: ed = bad_day(ey, em);
				2: sm = bad_month();
				3: em = bad_month();
				4: sy = bad_year();
				default: ey = bad_year();
			endcase
		end
		send_dates(sd, sm, sy, ed, em, ey);
	endtask

	// Result side: the stall rate changes from window to window, and one long
	// hold-off lets the counter fill up and raise full.
	initial begin : result_drain
		int  stall_left;
		int  drain_pct;
		int  window;
		bit  hold_done;
		stall_left = 0;
		drain_pct  = 0;
		window     = 0;
		hold_done  = 1'b0;
		pop = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (window == 0) begin
				case ($urandom_range(0, 2))
					0: drain_pct = 0;
					1: drain_pct = 15;
					default: drain_pct = 45;
				endcase
				window = 256;
			end
			window--;
			if (!hold_done && requests_sent >= HOLD_AT_REQUEST) begin
				stall_left = HOLD_CYCLES;
				hold_done  = 1'b1;
			end
			if (stall_left > 0) begin
				pop <= 1'b0;
				stall_left--;
			end else begin
				pop <= 1'b1;
				if ($urandom_range(0, 99) < drain_pct) stall_left = pick_gap();
			end
		end
	end

	initial begin : stimulus
		logic [6:0] phase_mask;
		int         phase_gap [RANDOM_PHASES];
		phase_gap = '{0, 20, 50, 10, 0, 35};
		arst_n    = 1'b0;
		push      = 1'b0;
		request   = '0;
		cfg_we    = 1'b0;
		cfg_wdata = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Calendar corner cases under the reset mask of Friday and Saturday.
		send_dates(15, 6, 2024, 15, 6, 2024);      sender_pause(30);
		send_dates(1, 3, 2024, 1, 1, 2024);        sender_pause(30);
		send_dates(1, 1, 2024, 2, 1, 2024);        sender_pause(30);
		send_dates(1, 1, 1, 5, 2, 2);              sender_pause(30);
		send_dates(28, 2, 1900, 1, 3, 1900);       sender_pause(30);
		send_dates(29, 2, 1900, 1, 3, 1900);       sender_pause(30);
		send_dates(29, 2, 2000, 1, 3, 2000);       sender_pause(30);
		send_dates(29, 2, 2100, 1, 3, 2100);       sender_pause(30);
		send_dates(29, 2, 2024, 1, 3, 2024);       sender_pause(30);
		send_dates(31, 4, 2023, 1, 5, 2023);       sender_pause(30);
		send_dates(10, 3, 2023, 31, 6, 2023);      sender_pause(30);
		send_dates(0, 1, 2023, 5, 1, 2023);        sender_pause(30);
		send_dates(1, 0, 2023, 5, 1, 2023);        sender_pause(30);
		send_dates(1, 13, 2023, 5, 1, 2024);       sender_pause(30);
		send_dates(1, 1, 0, 1, 1, 1);              sender_pause(30);
		send_dates(1, 1, 10000, 2, 1, 10000);      sender_pause(30);
		send_dates(31, 15, 16383, 31, 15, 16383);  sender_pause(30);
		send_dates(0, 0, 0, 0, 0, 0);              sender_pause(30);
		send_dates(1, 1, 9999, 31, 12, 9999);      sender_pause(30);
		send_dates(30, 12, 9999, 31, 12, 9999);    sender_pause(30);
		// The whole calendar saturates the count.
		send_dates(1, 1, 1, 31, 12, 9999);

		// No weekend at all: every day counts.
		write_weekend_mask(MASK_NONE);
		send_dates(1, 1, 1, 31, 12, 9999);
		send_dates(1, 1, 2000, 1, 1, 2001);

		// Every weekday masked: every count is zero.
		write_weekend_mask(BDC_MASK_ALL);
		send_dates(1, 1, 1, 31, 12, 9999);
		send_dates(1, 1, 2024, 1, 2, 2024);

		// Random requests, one weekend mask per phase.
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				0: phase_mask = MASK_SUN_SAT;
				2: phase_mask = BDC_MASK_RESET;
				4: phase_mask = MASK_SUN;
				default: phase_mask = 7'($urandom_range(0, 127));
			endcase
			write_weekend_mask(phase_mask);
			for (int i = 0; i < RANDOM_REQUESTS / RANDOM_PHASES; i++) begin
				random_request();
				sender_pause(phase_gap[p]);
			end
		end

		wait_for_drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Run covered %0d date range requests under %0d weekend masks, %0d results checked.",
			requests_sent, masks_written + 1, results_checked);
		$display("Of those, %0d had an invalid date and %0d hit the count ceiling.",
			bad_dates_seen, saturated_seen);
		if (failures == 0 && results_pending == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

[files.f]
hw/rtl/bdc_pkg.sv
hw/rtl/bdc_fifo.sv
hw/rtl/bdc_front.sv
hw/rtl/bdc_back.sv
hw/rtl/business_day_counter_top.sv
dv/bdc_checker.sv
dv/tb_business_day_counter_top.sv
